[design/bmpb_pkg.sv]
// Shared types and constants for the BMP pixel stream blitter.
`default_nettype none
package bmpb_pkg;

	localparam int MAX_IMAGE_DIM = 4096;
	localparam int DIM_W = 13;
	localparam int COORD_W = 12;
	localparam int INDEX_W = 25;
	localparam int COLOR_W = 24;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_INDEX_W = 3;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

	localparam logic [DIM_W-1:0] MAX_DIM = DIM_W'(MAX_IMAGE_DIM);
	localparam logic [COLOR_W-1:0] KEY_COLOR = 24'hFF0000;
	localparam logic [5:0] BPP_24 = 6'd24;
	localparam logic [5:0] BPP_32 = 6'd32;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_BITS_PER_PIXEL   = 3'd0,
		REG_IMAGE_WIDTH      = 3'd1,
		REG_IMAGE_HEIGHT     = 3'd2,
		REG_DEST_X           = 3'd3,
		REG_DEST_Y           = 3'd4,
		REG_VIEW_WIDTH       = 3'd5,
		REG_VIEW_HEIGHT      = 3'd6,
		REG_ROW_PITCH_PIXELS = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [5:0]             bits_per_pixel;
		logic [COORD_W-1:0]     image_width;
		logic signed [DIM_W-1:0] image_height;
		logic [COORD_W-1:0]     dest_x;
		logic [COORD_W-1:0]     dest_y;
		logic [DIM_W-1:0]       view_width;
		logic [DIM_W-1:0]       view_height;
		logic [DIM_W-1:0]       row_pitch_pixels;
	} cfg_t;

	typedef struct packed {
		logic [COLOR_W-1:0]      color;
		logic [COORD_W-1:0]      column;
		logic signed [DIM_W:0]   srow;
	} qent_t;

endpackage
`default_nettype wire

[design/bmpb_front.sv]
// Byte parser: assembles pixels, tracks row, column and padding, pushes candidates.
`default_nettype none
module bmpb_front (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire bmpb_pkg::cfg_t           cfg,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic [7:0]               pixel_byte,
	input  wire logic                     first_byte,
	input  wire logic                     q_full,
	output logic                          push,
	output bmpb_pkg::qent_t               push_data
);

	logic [1:0]                    pos_q, pos_n, pos_e;
	logic [7:0]                    blue_q, blue_n;
	logic [7:0]                    green_q, green_n;
	logic [bmpb_pkg::COORD_W-1:0]  col_q, col_n, col_e;
	logic [bmpb_pkg::DIM_W-1:0]    row_q, row_n, row_e, row_inc;
	logic [1:0]                    pad_q, pad_n, pad_e, pad_dec, pad_new;
	logic                          done_q, done_n, done_e;
	logic                          accept, depth_ok, is32;
	logic [1:0]                    last_pos;
	logic [bmpb_pkg::DIM_W-1:0]    w_eff, h_mag, h_eff;
	logic [bmpb_pkg::DIM_W-1:0]    col_inc;
	logic signed [bmpb_pkg::DIM_W:0] srow;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	assign w_eff = ({1'b0, cfg.image_width} > bmpb_pkg::MAX_DIM) ? bmpb_pkg::MAX_DIM
		: {1'b0, cfg.image_width};
	assign h_mag = cfg.image_height[bmpb_pkg::DIM_W-1] ? bmpb_pkg::DIM_W'(-cfg.image_height)
		: bmpb_pkg::DIM_W'(cfg.image_height);
	assign h_eff = (h_mag > bmpb_pkg::MAX_DIM) ? bmpb_pkg::MAX_DIM : h_mag;

	assign is32     = (cfg.bits_per_pixel == bmpb_pkg::BPP_32);
	assign depth_ok = is32 || (cfg.bits_per_pixel == bmpb_pkg::BPP_24);
	assign last_pos = is32 ? 2'd3 : 2'd2;
	assign pad_new  = is32 ? 2'd0 : w_eff[1:0];

	assign pos_e  = first_byte ? 2'd0 : pos_q;
	assign col_e  = first_byte ? '0 : col_q;
	assign row_e  = first_byte ? '0 : row_q;
	assign pad_e  = first_byte ? 2'd0 : pad_q;
	assign done_e = first_byte ? ((w_eff == '0) || (h_eff == '0)) : done_q;

	assign srow = cfg.image_height[bmpb_pkg::DIM_W-1] ? $signed({1'b0, row_e})
		: $signed({1'b0, h_eff}) - $signed({1'b0, row_e}) - 14'sd1;

	assign push_data = {pixel_byte, green_q, blue_q, col_e, srow};

	always_comb begin
		pos_n   = pos_q;
		blue_n  = blue_q;
		green_n = green_q;
		col_n   = col_q;
		row_n   = row_q;
		pad_n   = pad_q;
		done_n  = done_q;
		push    = 1'b0;
		pad_dec = pad_e - 2'd1;
		row_inc = row_e + 1'b1;
		col_inc = {1'b0, col_e} + 1'b1;
		if (accept) begin
			pos_n  = pos_e;
			col_n  = col_e;
			row_n  = row_e;
			pad_n  = pad_e;
			done_n = done_e;
			if (!done_e && depth_ok) begin
				if (pad_e != 2'd0) begin
					pad_n = pad_dec;
					if (pad_dec == 2'd0) begin
						col_n = '0;
						row_n = row_inc;
						if (row_inc >= h_eff) begin
							done_n = 1'b1;
						end
					end
				end else begin
					case (pos_e)
						2'd0: blue_n = pixel_byte;
						2'd1: green_n = pixel_byte;
						2'd2: push = 1'b1;
						default: ;
					endcase
					if (pos_e >= last_pos) begin
						pos_n = 2'd0;
						col_n = col_inc[bmpb_pkg::COORD_W-1:0];
						if (col_inc >= w_eff) begin
							if (pad_new == 2'd0) begin
								col_n = '0;
								row_n = row_inc;
								if (row_inc >= h_eff) begin
									done_n = 1'b1;
								end
							end else begin
								pad_n = pad_new;
							end
						end
					end else begin
						pos_n = pos_e + 2'd1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= 2'd0;
			blue_q  <= '0;
			green_q <= '0;
			col_q   <= '0;
			row_q   <= '0;
			pad_q   <= 2'd0;
			done_q  <= 1'b1;
		end else begin
			pos_q   <= pos_n;
			blue_q  <= blue_n;
			green_q <= green_n;
			col_q   <= col_n;
			row_q   <= row_n;
			pad_q   <= pad_n;
			done_q  <= done_n;
		end
	end

endmodule
`default_nettype wire

[design/bmpb_queue.sv]
// Short queue of pixel candidates between parser and output pipeline.
`default_nettype none
module bmpb_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire bmpb_pkg::qent_t    push_data,
	input  wire logic               pop,
	output bmpb_pkg::qent_t         pop_data,
	output logic                    full,
	output logic                    empty
);

	bmpb_pkg::qent_t                 mem_q [bmpb_pkg::QUEUE_DEPTH];
	logic [bmpb_pkg::QUEUE_AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [bmpb_pkg::QUEUE_CW-1:0]   count_q;

	assign full     = (count_q == bmpb_pkg::QUEUE_CW'(bmpb_pkg::QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) !(pop && empty))
		else $error("queue pop while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= bmpb_pkg::QUEUE_CW'(bmpb_pkg::QUEUE_DEPTH))
		else $error("queue count out of range");

endmodule
`default_nettype wire

[design/bmpb_back.sv]
// Output pipeline: clip and key test, then framebuffer index multiply.
`default_nettype none
module bmpb_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire bmpb_pkg::cfg_t                cfg,
	input  wire logic                          q_empty,
	input  wire bmpb_pkg::qent_t               q_data,
	output logic                               pop,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [bmpb_pkg::INDEX_W-1:0]       pixel_index,
	output logic [bmpb_pkg::COLOR_W-1:0]       pixel_color
);

	logic                           valid_s1, valid_s2;
	logic [bmpb_pkg::DIM_W-1:0]     px_s1, py_s1;
	logic [bmpb_pkg::COLOR_W-1:0]   color_s1, color_s2;
	logic [bmpb_pkg::INDEX_W-1:0]   index_s2;
	logic                           adv1, adv2, keep;
	logic [bmpb_pkg::DIM_W-1:0]     px, py;
	logic [2*bmpb_pkg::DIM_W-1:0]   index_full;

	assign adv2 = !valid_s2 || !out_stall;
	assign adv1 = !valid_s1 || adv2;
	assign pop  = adv1 && !q_empty;

	assign px   = {1'b0, cfg.dest_x} + {1'b0, q_data.column};
	assign py   = {1'b0, cfg.dest_y} + q_data.srow[bmpb_pkg::DIM_W-1:0];
	assign keep = !q_data.srow[bmpb_pkg::DIM_W] && (px < cfg.view_width)
		&& (py < cfg.view_height) && (q_data.color != bmpb_pkg::KEY_COLOR);

	assign index_full = py_s1 * cfg.row_pitch_pixels + {{bmpb_pkg::DIM_W{1'b0}}, px_s1};

	always_ff @(posedge clk) begin
		if (adv1) begin
			px_s1    <= px;
			py_s1    <= py;
			color_s1 <= q_data.color;
		end
		if (adv2) begin
			index_s2 <= index_full[bmpb_pkg::INDEX_W-1:0];
			color_s2 <= color_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv1) begin
				valid_s1 <= !q_empty && keep;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	assign out_valid   = valid_s2;
	assign pixel_index = index_s2;
	assign pixel_color = color_s2;

	a_no_key: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pixel_color != bmpb_pkg::KEY_COLOR))
		else $error("transparent color emitted");

endmodule
`default_nettype wire

[design/bmp_pixel_stream_blitter_top.sv]
// Top level of the BMP pixel stream blitter: registers, parser, queue, output pipeline.
// Throughput: one byte word per cycle while the queue is not full; the parser updates all
// position state for each byte it takes. A kept pixel's red byte is written into the queue,
// then passes the clip and key stage and the index multiply stage, which drives the output.
// The four-word queue lets the parser take bytes during an output stall until it is full.
// Reset clears all position state, marks the image done and loads register defaults.
`default_nettype none
module bmp_pixel_stream_blitter_top (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wr_en,
	input  wire logic [bmpb_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [bmpb_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [7:0]                        pixel_byte,
	input  wire logic                              first_byte,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [bmpb_pkg::INDEX_W-1:0]           pixel_index,
	output logic [bmpb_pkg::COLOR_W-1:0]           pixel_color
);

	bmpb_pkg::cfg_t   cfg_q;
	bmpb_pkg::qent_t  push_data, pop_data;
	logic             push, pop, q_full, q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= {bmpb_pkg::BPP_24, {($bits(bmpb_pkg::cfg_t) - 6){1'b0}}};
		end else if (cfg_wr_en) begin
			case (bmpb_pkg::cfg_reg_t'(cfg_index))
				bmpb_pkg::REG_BITS_PER_PIXEL:   cfg_q.bits_per_pixel   <= cfg_data[5:0];
				bmpb_pkg::REG_IMAGE_WIDTH:      cfg_q.image_width      <= cfg_data[11:0];
				bmpb_pkg::REG_IMAGE_HEIGHT:     cfg_q.image_height     <= $signed(cfg_data);
				bmpb_pkg::REG_DEST_X:           cfg_q.dest_x           <= cfg_data[11:0];
				bmpb_pkg::REG_DEST_Y:           cfg_q.dest_y           <= cfg_data[11:0];
				bmpb_pkg::REG_VIEW_WIDTH:       cfg_q.view_width       <= cfg_data;
				bmpb_pkg::REG_VIEW_HEIGHT:      cfg_q.view_height      <= cfg_data;
				bmpb_pkg::REG_ROW_PITCH_PIXELS: cfg_q.row_pitch_pixels <= cfg_data;
				default: ;
			endcase
		end
	end

	bmpb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.pixel_byte (pixel_byte),
		.first_byte (first_byte),
		.q_full     (q_full),
		.push       (push),
		.push_data  (push_data)
	);

	bmpb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.pop        (pop),
		.pop_data   (pop_data),
		.full       (q_full),
		.empty      (q_empty)
	);

	bmpb_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_empty     (q_empty),
		.q_data      (pop_data),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pixel_index (pixel_index),
		.pixel_color (pixel_color)
	);

endmodule
`default_nettype wire

[dv/bmp_pixel_stream_blitter_checker.sv]
// Checker for the BMP pixel stream blitter: tracks registers, predicts kept pixels, compares words.
module bmp_pixel_stream_blitter_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [bmpb_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [bmpb_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	input  logic                             in_stall,
	input  logic [7:0]                       pixel_byte,
	input  logic                             first_byte,
	input  logic                             out_valid,
	input  logic                             out_stall,
	input  logic [bmpb_pkg::INDEX_W-1:0]     pixel_index,
	input  logic [bmpb_pkg::COLOR_W-1:0]     pixel_color,
	output int unsigned                      fail_count,
	output int unsigned                      pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [bmpb_pkg::INDEX_W-1:0] index;
		logic [bmpb_pkg::COLOR_W-1:0] color;
	} pixel_t;

	pixel_t expected_pixels [$];
	pixel_t word_exp;

	logic [5:0]                        bpp;
	logic [bmpb_pkg::COORD_W-1:0]      img_w;
	logic signed [bmpb_pkg::DIM_W-1:0] img_h;
	logic [bmpb_pkg::COORD_W-1:0]      dx;
	logic [bmpb_pkg::COORD_W-1:0]      dy;
	logic [bmpb_pkg::DIM_W-1:0]        scr_w;
	logic [bmpb_pkg::DIM_W-1:0]        scr_h;
	logic [bmpb_pkg::DIM_W-1:0]        pitch;

	logic [1:0]  byte_pos;
	logic [7:0]  blue;
	logic [7:0]  green;
	int unsigned col;
	int unsigned src_row;
	logic [1:0]  pad_left;
	bit          done;

	task automatic report_mismatch(input string msg);
		if (fail_count < 200)
			$display("%0t ns mismatch: %s", $time, msg);
		fail_count++;
	endtask

	task automatic next_row(input int unsigned h);
		col = 0;
		src_row++;
		if (src_row >= h)
			done = 1'b1;
	endtask

	task automatic blit_byte(input logic [7:0] b, input logic fb);
		int hv;
		int unsigned w;
		int unsigned h;
		int unsigned last_pos;
		int unsigned pad;
		logic [31:0] srow;
		logic [bmpb_pkg::COLOR_W-1:0] color;
		longint unsigned px;
		longint unsigned py;
		pixel_t word;
		w = img_w;
		hv = int'(img_h);
		h = (hv < 0) ? -hv : hv;
		if (fb) begin
			byte_pos = 0;
			col = 0;
			src_row = 0;
			pad_left = 0;
			done = (w == 0 || h == 0);
		end
		if (done)
			return;
		if (bpp != bmpb_pkg::BPP_24 && bpp != bmpb_pkg::BPP_32)
			return;
		if (pad_left != 0) begin
			pad_left--;
			if (pad_left == 0)
				next_row(h);
			return;
		end
		last_pos = (bpp == bmpb_pkg::BPP_32) ? 3 : 2;
		case (byte_pos)
			2'd0: blue = b;
			2'd1: green = b;
			2'd2: begin
				color = {b, green, blue};
				srow = (hv < 0) ? 32'(src_row) : 32'(h) - 32'd1 - 32'(src_row);
				px = 64'(dx) + 64'(col);
				py = 64'(dy) + 64'(srow);
				if (px < 64'(scr_w) && py < 64'(scr_h) && color != bmpb_pkg::KEY_COLOR) begin
					word.index = bmpb_pkg::INDEX_W'(py * 64'(pitch) + px);
					word.color = color;
					expected_pixels.push_back(word);
				end
			end
			default: ;
		endcase
		if (byte_pos >= last_pos) begin
			byte_pos = 0;
			col++;
			if (col >= w) begin
				pad = (bpp == bmpb_pkg::BPP_32) ? 0 : (4 - ((w * 3) & 3)) & 3;
				if (pad == 0)
					next_row(h);
				else
					pad_left = 2'(pad);
			end
		end else begin
			byte_pos = byte_pos + 2'd1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp = bmpb_pkg::BPP_24;
			img_w = '0;
			img_h = '0;
			dx = '0;
			dy = '0;
			scr_w = '0;
			scr_h = '0;
			pitch = '0;
			byte_pos = '0;
			blue = '0;
			green = '0;
			col = 0;
			src_row = 0;
			pad_left = '0;
			done = 1'b1;
			expected_pixels.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_wr_en) begin
				case (bmpb_pkg::cfg_reg_t'(cfg_index))
					bmpb_pkg::REG_BITS_PER_PIXEL:   bpp = cfg_data[5:0];
					bmpb_pkg::REG_IMAGE_WIDTH:      img_w = cfg_data[bmpb_pkg::COORD_W-1:0];
					bmpb_pkg::REG_IMAGE_HEIGHT:     img_h = cfg_data;
					bmpb_pkg::REG_DEST_X:           dx = cfg_data[bmpb_pkg::COORD_W-1:0];
					bmpb_pkg::REG_DEST_Y:           dy = cfg_data[bmpb_pkg::COORD_W-1:0];
					bmpb_pkg::REG_VIEW_WIDTH:       scr_w = cfg_data;
					bmpb_pkg::REG_VIEW_HEIGHT:      scr_h = cfg_data;
					bmpb_pkg::REG_ROW_PITCH_PIXELS: pitch = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				blit_byte(pixel_byte, first_byte);
			if (out_valid && !out_stall) begin
				if (expected_pixels.size() == 0) begin
					report_mismatch($sformatf("unexpected word index %0h color %06h",
						pixel_index, pixel_color));
				end else begin
					word_exp = expected_pixels.pop_front();
					if (pixel_index !== word_exp.index)
						report_mismatch($sformatf("index got %0h want %0h",
							pixel_index, word_exp.index));
					if (pixel_color !== word_exp.color)
						report_mismatch($sformatf("color got %06h want %06h",
							pixel_color, word_exp.color));
				end
			end
			pending = expected_pixels.size();
		end
	end

endmodule

[dv/bmp_pixel_stream_blitter_top_tb.sv]
// Testbench top for the BMP pixel stream blitter: clock, reset, byte and register stimulus, verdict.
module bmp_pixel_stream_blitter_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 10;
	localparam int BYTE_TARGET = 950;

	logic                             clk = 1'b0;
	logic                             arst_n;
	logic                             cfg_wr_en;
	logic [bmpb_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [bmpb_pkg::CFG_DATA_W-1:0]  cfg_data;
	logic                             in_valid;
	logic                             in_stall;
	logic [7:0]                       pixel_byte;
	logic                             first_byte;
	logic                             out_valid;
	logic                             out_stall;
	logic [bmpb_pkg::INDEX_W-1:0]     pixel_index;
	logic [bmpb_pkg::COLOR_W-1:0]     pixel_color;
	int unsigned                      fail_count;
	int unsigned                      pending;

	int          idle_pct;
	int          stall_pct;
	int unsigned cycles = 0;
	int          image_bytes;

	logic [5:0]                        t_bpp;
	logic [bmpb_pkg::COORD_W-1:0]      t_w;
	logic signed [bmpb_pkg::DIM_W-1:0] t_h;

	bmp_pixel_stream_blitter_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.pixel_byte  (pixel_byte),
		.first_byte  (first_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pixel_index (pixel_index),
		.pixel_color (pixel_color)
	);

	bmp_pixel_stream_blitter_checker pixel_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.pixel_byte  (pixel_byte),
		.first_byte  (first_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pixel_index (pixel_index),
		.pixel_color (pixel_color),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	always #10ns clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	task automatic send_byte(input logic [7:0] value, input bit fb);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		pixel_byte <= value;
		first_byte <= fb;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input bmpb_pkg::cfg_reg_t idx,
		input logic [bmpb_pkg::CFG_DATA_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	task automatic program_regs(input logic [5:0] bpp, input logic [bmpb_pkg::COORD_W-1:0] w,
		input logic [bmpb_pkg::DIM_W-1:0] h, input logic [bmpb_pkg::COORD_W-1:0] x,
		input logic [bmpb_pkg::COORD_W-1:0] y, input logic [bmpb_pkg::DIM_W-1:0] sw,
		input logic [bmpb_pkg::DIM_W-1:0] sh, input logic [bmpb_pkg::DIM_W-1:0] pitch);
		t_bpp = bpp;
		t_w = w;
		t_h = h;
		write_reg(bmpb_pkg::REG_BITS_PER_PIXEL, bmpb_pkg::CFG_DATA_W'(bpp));
		write_reg(bmpb_pkg::REG_IMAGE_WIDTH, bmpb_pkg::CFG_DATA_W'(w));
		write_reg(bmpb_pkg::REG_IMAGE_HEIGHT, h);
		write_reg(bmpb_pkg::REG_DEST_X, bmpb_pkg::CFG_DATA_W'(x));
		write_reg(bmpb_pkg::REG_DEST_Y, bmpb_pkg::CFG_DATA_W'(y));
		write_reg(bmpb_pkg::REG_VIEW_WIDTH, sw);
		write_reg(bmpb_pkg::REG_VIEW_HEIGHT, sh);
		write_reg(bmpb_pkg::REG_ROW_PITCH_PIXELS, pitch);
	endtask

	// drop valid, wait out every expected word, then let the pipeline go quiet
	task automatic settle();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
	endtask

	task automatic choose_settings(input int phase);
		logic [5:0]                   bpp;
		logic [bmpb_pkg::COORD_W-1:0] w;
		logic [bmpb_pkg::DIM_W-1:0]   h;
		logic [bmpb_pkg::COORD_W-1:0] x;
		logic [bmpb_pkg::COORD_W-1:0] y;
		logic [bmpb_pkg::DIM_W-1:0]   sw;
		logic [bmpb_pkg::DIM_W-1:0]   sh;
		logic [bmpb_pkg::DIM_W-1:0]   pitch;
		int r;
		case (phase)
			0: program_regs(bmpb_pkg::BPP_32, 12'd4095, 13'h1000, 12'd4095, 12'd4095,
				13'd4096, 13'd4096, 13'd8191);
			1: program_regs(6'd0, '0, '0, '0, '0, '0, '0, '0);
			2: program_regs(bmpb_pkg::BPP_24, 12'd4095, 13'd4095, '0, '0, 13'd4096, 13'd4096,
				13'd8191);
			3: program_regs(6'd63, 12'd3, 13'd2, '0, '0, 13'd4096, 13'd4096, 13'd64);
			default: begin
				r = $urandom_range(11);
				if (r < 5)
					bpp = bmpb_pkg::BPP_24;
				else if (r < 10)
					bpp = bmpb_pkg::BPP_32;
				else if (r == 10)
					bpp = 6'($urandom_range(63));
				else
					bpp = $urandom_range(1) ? 6'd63 : 6'd0;
				r = $urandom_range(9);
				w = (r < 8) ? 12'($urandom_range(1, 6)) :
					(r == 8) ? 12'($urandom_range(4095)) : 12'd0;
				r = $urandom_range(19);
				if (r < 16) begin
					h = 13'($urandom_range(1, 4));
					if ($urandom_range(1))
						h = -h;
				end else if (r == 16) begin
					h = '0;
				end else if (r == 17) begin
					h = 13'd4095;
				end else if (r == 18) begin
					h = 13'h1000;
				end else begin
					h = 13'($urandom);
				end
				r = $urandom_range(19);
				x = (r < 12) ? 12'($urandom_range(4)) :
					(r < 17) ? 12'($urandom) : 12'd4095;
				r = $urandom_range(19);
				y = (r < 12) ? 12'($urandom_range(4)) :
					(r < 17) ? 12'($urandom) : 12'd4095;
				r = $urandom_range(9);
				sw = (r < 6) ? 13'd4096 :
					(r < 8) ? 13'(x + $urandom_range(4)) : 13'($urandom_range(4096));
				if (sw > 13'd4096)
					sw = 13'd4096;
				r = $urandom_range(9);
				sh = (r < 6) ? 13'd4096 :
					(r < 8) ? 13'(y + $urandom_range(4)) : 13'($urandom_range(4096));
				if (sh > 13'd4096)
					sh = 13'd4096;
				r = $urandom_range(9);
				pitch = (r < 4) ? 13'($urandom) : (r < 8) ? 13'($urandom_range(1, 16)) :
					(r == 8) ? 13'd8191 : 13'd0;
				program_regs(bpp, w, h, x, y, sw, sh, pitch);
			end
		endcase
	endtask

	task automatic send_image(input bit fresh);
		logic [7:0] stream [$];
		logic [bmpb_pkg::COLOR_W-1:0] color;
		int hv;
		int rows;
		int nb;
		int pad;
		int cap;
		int r;
		int c;
		int p;
		int i;
		bit active;
		hv = int'(t_h);
		rows = (hv < 0) ? -hv : hv;
		active = (t_bpp == bmpb_pkg::BPP_24 || t_bpp == bmpb_pkg::BPP_32) && t_w != 0
			&& rows != 0;
		nb = (t_bpp == bmpb_pkg::BPP_32) ? 4 : 3;
		pad = (t_bpp == bmpb_pkg::BPP_32) ? 0 : (4 - ((int'(t_w) * 3) & 3)) & 3;
		cap = ($urandom_range(7) == 0) ? $urandom_range(2, 30) : 96;
		if (!active || $urandom_range(19) == 0) begin
			repeat ($urandom_range(4, 16))
				stream.push_back(8'($urandom));
		end else begin
			for (r = 0; r < rows && stream.size() < cap; r++) begin
				for (c = 0; c < int'(t_w) && stream.size() < cap; c++) begin
					p = $urandom_range(19);
					color = (p < 2) ? bmpb_pkg::KEY_COLOR : (p == 2) ? 24'hFFFFFF :
						(p == 3) ? 24'h000000 : 24'($urandom);
					stream.push_back(color[7:0]);
					stream.push_back(color[15:8]);
					stream.push_back(color[23:16]);
					if (nb == 4)
						stream.push_back(8'($urandom));
				end
				for (p = 0; p < pad; p++)
					stream.push_back(8'($urandom));
			end
			if (stream.size() <= cap) begin
				repeat ($urandom_range(3))
					stream.push_back(8'($urandom));
			end
			while (stream.size() > cap)
				void'(stream.pop_back());
		end
		for (i = 0; i < stream.size(); i++)
			send_byte(stream[i], (i == 0 && fresh) || $urandom_range(99) == 0);
		image_bytes += stream.size();
	endtask

	initial begin
		logic [7:0] demo [0:15];
		int i;
		int phase;
		demo = '{8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hAA, 8'h55,
			8'h00, 8'h00, 8'h00, 8'h03, 8'h02, 8'h01, 8'h5A, 8'hA5};
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = bmpb_pkg::REG_BITS_PER_PIXEL;
		cfg_data = '0;
		in_valid = 1'b0;
		pixel_byte = '0;
		first_byte = 1'b0;
		out_stall = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		image_bytes = 0;
		t_bpp = bmpb_pkg::BPP_24;
		t_w = '0;
		t_h = '0;
		repeat (5)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// ignored before any image start, then an empty image
		send_byte(8'h3C, 1'b0);
		send_byte(8'hC3, 1'b0);
		send_byte(8'h81, 1'b1);
		settle();

		// 2x2 bottom-up with the key color, row padding and bytes past the end
		program_regs(bmpb_pkg::BPP_24, 12'd2, 13'd2, 12'd1, 12'd0, 13'd4096, 13'd4096,
			13'd8191);
		for (i = 0; i < 16; i++)
			send_byte(demo[i], i == 0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		settle();

		phase = 0;
		while (image_bytes < BYTE_TARGET) begin
			case (phase % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 67; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 67; end
				default: begin idle_pct = 32; stall_pct = 32; end
			endcase
			choose_settings(phase);
			// the first image of a phase may carry on from the old settings
			send_image($urandom_range(3) != 0);
			repeat ($urandom_range(2))
				send_image(1'b1);
			settle();
			phase++;
		end

		repeat (2 * SETTLE_CYCLES)
			@(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
